// File: rtl/nearest_palette_color_assert.svh
// Assertion macros for the nearest palette colour block.
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define NPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define NPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define NPC_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/npc_pkg.sv
// Package with the palette table, widths and types of the nearest palette colour block.
`default_nettype none

package npc_pkg;

  localparam int COMP_W        = 8;
  localparam int SQ_W          = 2 * COMP_W;
  localparam int DIST_W        = 18;
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int NUM_COMPS     = 3;
  localparam int NUM_LEVELS    = 3;
  localparam int LEVEL_W       = 2;
  localparam int GROUP_SIZE    = 4;
  localparam int NUM_GROUPS    = TABLE_ENTRIES / GROUP_SIZE;
  localparam int DEFAULT_PALETTE_SIZE = 16;
  localparam logic [DIST_W-1:0] MAX_DISTANCE = DIST_W'(195075);

  localparam int COMP_RED   = 0;
  localparam int COMP_GREEN = 1;
  localparam int COMP_BLUE  = 2;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } cand_t;

  localparam logic [COMP_W-1:0] LEVELS [NUM_LEVELS] = '{8'h00, 8'h7F, 8'hFF};

  localparam rgb_t PALETTE [TABLE_ENTRIES] = '{
    '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h7F},
    '{8'h00, 8'h7F, 8'h00}, '{8'h00, 8'h7F, 8'h7F},
    '{8'h7F, 8'h00, 8'h00}, '{8'h7F, 8'h00, 8'h7F},
    '{8'h7F, 8'h7F, 8'h00}, '{8'h7F, 8'h7F, 8'h7F},
    '{8'h7F, 8'h7F, 8'h7F}, '{8'h7F, 8'h7F, 8'hFF},
    '{8'h7F, 8'hFF, 8'h7F}, '{8'h7F, 8'hFF, 8'hFF},
    '{8'hFF, 8'h7F, 8'h7F}, '{8'hFF, 8'h7F, 8'hFF},
    '{8'hFF, 8'hFF, 8'h7F}, '{8'hFF, 8'hFF, 8'hFF}
  };

  // Every palette component is one of the three levels; this gives its position.
  function automatic logic [LEVEL_W-1:0] level_of(input logic [COMP_W-1:0] v);
    logic [LEVEL_W-1:0] code;
    code = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (LEVELS[l] == v) begin
        code = LEVEL_W'(l);
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nearest_palette_color.sv
// Top level of the nearest palette colour block: a five-stage search pipeline.
//
//  Channel | Direction | Contents of tdata (lowest bit first)
//  s_      | in        | red[7:0], green[15:8], blue[23:16]
//  m_      | out       | palette_index[3:0], pal_red[11:4], pal_green[19:12],
//          |           | pal_blue[27:20], min_distance[45:28], zero[47:46]
//
// One pixel enters per clock unless the output stalls, and its result is registered in each stage in turn.
// The stages are component differences, squares, per-entry sums and two levels of minimum search.
// Each stage holds its own valid bit and takes new data whenever it is empty or its successor moves.
// A stalled output therefore fills the empty stages before the input stops.
// Reset clears the valid bits only.
`default_nettype none

module nearest_palette_color #(
  parameter int PALETTE_SIZE = npc_pkg::DEFAULT_PALETTE_SIZE
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red, green, blue
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // palette_index, pal_red, pal_green, pal_blue, min_distance
);

  localparam int SEARCH = (PALETTE_SIZE < npc_pkg::TABLE_ENTRIES) ?
                          PALETTE_SIZE : npc_pkg::TABLE_ENTRIES;

  localparam int CW = npc_pkg::COMP_W;
  localparam int NC = npc_pkg::NUM_COMPS;
  localparam int NL = npc_pkg::NUM_LEVELS;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [CW-1:0]                s1_diff      [NC][NL];
  logic [CW-1:0]                s1_diff_next [NC][NL];
  logic [npc_pkg::SQ_W-1:0]     s2_sq        [NC][NL];
  logic [npc_pkg::SQ_W-1:0]     s2_sq_next   [NC][NL];
  logic [npc_pkg::DIST_W-1:0]   s3_dist      [npc_pkg::TABLE_ENTRIES];
  logic [npc_pkg::DIST_W-1:0]   s3_dist_next [npc_pkg::TABLE_ENTRIES];
  npc_pkg::cand_t               s4_cand      [npc_pkg::NUM_GROUPS];
  npc_pkg::cand_t               s4_cand_next [npc_pkg::NUM_GROUPS];
  npc_pkg::cand_t               s5_best;
  npc_pkg::cand_t               s5_best_next;
  npc_pkg::rgb_t                s5_pal;

  logic [CW-1:0] in_comp [NC];

  assign rdy5 = !v5 || m_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_tready = rdy1;

  assign in_comp[npc_pkg::COMP_RED]   = s_tdata[7:0];
  assign in_comp[npc_pkg::COMP_GREEN] = s_tdata[15:8];
  assign in_comp[npc_pkg::COMP_BLUE]  = s_tdata[23:16];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      for (int l = 0; l < NL; l++) begin
        s1_diff_next[c][l] = (in_comp[c] >= npc_pkg::LEVELS[l]) ?
                             (in_comp[c] - npc_pkg::LEVELS[l]) :
                             (npc_pkg::LEVELS[l] - in_comp[c]);
        s2_sq_next[c][l]   = npc_pkg::SQ_W'(s1_diff[c][l]) * npc_pkg::SQ_W'(s1_diff[c][l]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < npc_pkg::TABLE_ENTRIES; i++) begin
      s3_dist_next[i] =
        npc_pkg::DIST_W'(s2_sq[npc_pkg::COMP_RED]
                              [npc_pkg::level_of(npc_pkg::PALETTE[i].red)]) +
        npc_pkg::DIST_W'(s2_sq[npc_pkg::COMP_GREEN]
                              [npc_pkg::level_of(npc_pkg::PALETTE[i].green)]) +
        npc_pkg::DIST_W'(s2_sq[npc_pkg::COMP_BLUE]
                              [npc_pkg::level_of(npc_pkg::PALETTE[i].blue)]);
    end
  end

  // Entries past the searched range carry the largest code and never win; ties keep the earlier entry.
  always_comb begin
    for (int g = 0; g < npc_pkg::NUM_GROUPS; g++) begin
      s4_cand_next[g].idx      = npc_pkg::IDX_W'(g * npc_pkg::GROUP_SIZE);
      s4_cand_next[g].distance = (g * npc_pkg::GROUP_SIZE < SEARCH) ?
                                 s3_dist[g * npc_pkg::GROUP_SIZE] : '1;
      for (int j = 1; j < npc_pkg::GROUP_SIZE; j++) begin
        if ((g * npc_pkg::GROUP_SIZE + j < SEARCH) &&
            (s3_dist[g * npc_pkg::GROUP_SIZE + j] < s4_cand_next[g].distance)) begin
          s4_cand_next[g].idx      = npc_pkg::IDX_W'(g * npc_pkg::GROUP_SIZE + j);
          s4_cand_next[g].distance = s3_dist[g * npc_pkg::GROUP_SIZE + j];
        end
      end
    end
  end

  always_comb begin
    s5_best_next = s4_cand[0];
    for (int g = 1; g < npc_pkg::NUM_GROUPS; g++) begin
      if (s4_cand[g].distance < s5_best_next.distance) begin
        s5_best_next = s4_cand[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= s_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_diff <= s1_diff_next;
    end
    if (rdy2) begin
      s2_sq <= s2_sq_next;
    end
    if (rdy3) begin
      s3_dist <= s3_dist_next;
    end
    if (rdy4) begin
      s4_cand <= s4_cand_next;
    end
    if (rdy5) begin
      s5_best <= s5_best_next;
      s5_pal  <= npc_pkg::PALETTE[s5_best_next.idx];
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {2'b00, s5_best.distance, s5_pal.blue, s5_pal.green, s5_pal.red,
                     s5_best.idx};

  `include "nearest_palette_color_assert.svh"

  `NPC_ASSERT_ALWAYS(a_reset_clears, clk, rst, !m_tvalid, "Output valid after reset.")
  `NPC_ASSERT_NOW(a_index_range, clk, rst, m_tvalid, 32'(s5_best.idx) < SEARCH, "Index beyond the searched palette.")
  `NPC_ASSERT_NOW(a_colour_match, clk, rst, m_tvalid, s5_pal == npc_pkg::PALETTE[s5_best.idx], "Colour does not match the index.")
  `NPC_ASSERT_NOW(a_distance_range, clk, rst, m_tvalid, s5_best.distance <= npc_pkg::MAX_DISTANCE, "Distance out of range.")
  `NPC_ASSERT_NEXT(a_stage_moves, clk, rst, v4 && rdy5, v5, "Transfer lost between the last two stages.")

endmodule

`default_nettype wire
